### design/lmn_pkg.sv
// Package for the Lamport mutual exclusion node: sizes, item codes, state type
// and the saturating clock and counter helpers.
// Depends on nothing; used by lamport_mutex_node.
package lmn_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int STAMP_W   = 15;
    localparam int MIN_NODES = 3;

    localparam logic [STAMP_W-1:0] SLOT_EMPTY = 15'd32767;
    localparam logic [STAMP_W-1:0] CLOCK_TOP  = 15'd32766;
    localparam logic [4:0]         COUNT_TOP  = 5'd31;

    // Local opcodes.
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_DONE    = 2'd2;
    localparam logic [1:0] OP_MESSAGE = 2'd3;

    // Received message kinds.
    localparam logic [2:0] MSG_REQUEST = 3'd0;
    localparam logic [2:0] MSG_REPLY   = 3'd1;
    localparam logic [2:0] MSG_RELEASE = 3'd2;
    localparam logic [2:0] MSG_DONE    = 3'd3;

    // Outgoing message kinds.
    localparam logic [2:0] SEND_NONE    = 3'd0;
    localparam logic [2:0] SEND_REQUEST = 3'd1;
    localparam logic [2:0] SEND_REPLY   = 3'd2;
    localparam logic [2:0] SEND_RELEASE = 3'd3;
    localparam logic [2:0] SEND_DONE    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_OWN_ID     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    function automatic logic [STAMP_W-1:0] clock_tick(input logic [STAMP_W-1:0] c);
        return (c < CLOCK_TOP) ? c + 15'd1 : CLOCK_TOP;
    endfunction

    function automatic logic [4:0] count_inc(input logic [4:0] c);
        return (c < COUNT_TOP) ? c + 5'd1 : COUNT_TOP;
    endfunction

endpackage

### design/lamport_mutex_node.sv
// An accepted item passes through the states ST_SCAN, ST_DRAIN and ST_RESULT and then the
// output register; the result strobe lasts one cycle. n is node_count clamped to 3..16.
// busy holds off a new item until the state is back in ST_IDLE. The scan of slots 1..n-1 uses the
// single read port of the slot memory, one entry per cycle; results cannot be held off.
// Reset (synchronous, active low) clears the clock, counters and slot valid bits and
// loads node_count 9 and own_id 1. Depends on lmn_pkg.
module lamport_mutex_node (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_msg_kind,
    input  logic [3:0]  i_sender,
    input  logic [14:0] i_msg_stamp,
    output logic        o_valid,
    output logic [2:0]  o_send_kind,
    output logic [3:0]  o_send_dest,
    output logic [14:0] o_send_stamp,
    output logic [14:0] o_clock_now,
    output logic        o_may_enter,
    output logic        o_bad_kind
);

    // Configuration.
    logic [4:0] r_node_count;
    logic [3:0] r_own_id;

    // Node state.
    logic [14:0] r_clock;
    logic [4:0]  r_replies;
    logic [4:0]  r_dones;

    // Slot memory with one valid bit per entry; an invalid entry reads as empty.
    logic [14:0]                  r_slots [lmn_pkg::MAX_NODES];
    logic [lmn_pkg::MAX_NODES-1:0] r_slot_valid;

    // Sequencer and scan.
    lmn_pkg::t_state             r_state, n_state;
    logic [lmn_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic                        r_rd_live;
    logic [lmn_pkg::IDX_W-1:0]   r_rd_addr;
    logic [14:0]                 r_rd_data;
    logic                        r_rd_valid;
    logic [14:0]                 r_best;
    logic [lmn_pkg::IDX_W-1:0]   r_who;

    // Held result fields.
    logic [2:0]  r_kind;
    logic [3:0]  r_dest;
    logic [14:0] r_stamp;
    logic        r_bad;

    // Output register.
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [3:0]  r_out_dest;
    logic [14:0] r_out_stamp;
    logic [14:0] r_out_clock;
    logic        r_out_enter;
    logic        r_out_bad;

    logic                      accept;
    logic                      cfg_write;
    logic [lmn_pkg::CNT_W-1:0] eff_nodes;
    logic [4:0]                peers;
    logic [14:0]               tick_clock;
    logic [14:0]               msg_clock;
    logic [14:0]               new_clock;
    logic [4:0]                new_replies;
    logic [4:0]                new_dones;
    logic                      wr_en;
    logic [3:0]                wr_addr;
    logic [14:0]               wr_data;
    logic [2:0]                new_kind;
    logic [3:0]                new_dest;
    logic [14:0]               new_stamp;
    logic                      new_bad;
    logic [14:0]               rd_value;
    logic                      enter;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign accept    = start && !busy;

    always_comb begin
        unique case (paddr[2])
            lmn_pkg::REG_NODE_COUNT: prdata = {27'd0, r_node_count};
            lmn_pkg::REG_OWN_ID:     prdata = {28'd0, r_own_id};
            default:                 prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (int'(r_node_count) < lmn_pkg::MIN_NODES) begin
            eff_nodes = lmn_pkg::CNT_W'(lmn_pkg::MIN_NODES);
        end else if (int'(r_node_count) > lmn_pkg::MAX_NODES) begin
            eff_nodes = lmn_pkg::CNT_W'(lmn_pkg::MAX_NODES);
        end else begin
            eff_nodes = lmn_pkg::CNT_W'(r_node_count);
        end
    end

    assign peers = 5'(int'(eff_nodes) - 2);

    // Work done at the accepting edge: clock, counters and the one slot write.
    always_comb begin
        tick_clock  = lmn_pkg::clock_tick(r_clock);
        msg_clock   = tick_clock;
        new_clock   = tick_clock;
        new_replies = r_replies;
        new_dones   = r_dones;
        wr_en       = 1'b0;
        wr_addr     = r_own_id;
        wr_data     = lmn_pkg::SLOT_EMPTY;
        new_kind    = lmn_pkg::SEND_NONE;
        new_dest    = 4'd0;
        new_stamp   = 15'd0;
        new_bad     = 1'b0;
        if (i_msg_stamp > r_clock) begin
            msg_clock = (i_msg_stamp < lmn_pkg::CLOCK_TOP) ? i_msg_stamp + 15'd1
                                                          : lmn_pkg::CLOCK_TOP;
        end
        case (i_opcode)
            lmn_pkg::OP_REQUEST: begin
                wr_en     = 1'b1;
                wr_data   = tick_clock;
                new_kind  = lmn_pkg::SEND_REQUEST;
                new_stamp = tick_clock;
            end
            lmn_pkg::OP_RELEASE: begin
                wr_en       = 1'b1;
                new_replies = 5'd0;
                new_kind    = lmn_pkg::SEND_RELEASE;
                new_stamp   = tick_clock;
            end
            lmn_pkg::OP_DONE: begin
                new_replies = peers;
                new_kind    = lmn_pkg::SEND_DONE;
                new_stamp   = tick_clock;
            end
            default: begin
                new_clock = msg_clock;
                case (i_msg_kind)
                    lmn_pkg::MSG_REQUEST: begin
                        // A request is stored and answered after a second tick.
                        wr_en     = 1'b1;
                        wr_addr   = i_sender;
                        wr_data   = i_msg_stamp;
                        new_clock = lmn_pkg::clock_tick(msg_clock);
                        new_kind  = lmn_pkg::SEND_REPLY;
                        new_dest  = i_sender;
                        new_stamp = lmn_pkg::clock_tick(msg_clock);
                    end
                    lmn_pkg::MSG_REPLY:   new_replies = lmn_pkg::count_inc(r_replies);
                    lmn_pkg::MSG_RELEASE: begin
                        wr_en   = 1'b1;
                        wr_addr = i_sender;
                    end
                    lmn_pkg::MSG_DONE:    new_dones = lmn_pkg::count_inc(r_dones);
                    default:              new_bad = 1'b1;
                endcase
            end
        endcase
    end

    // Sequencer: scan slots 1..n-1, wait for the last read, then publish.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        busy    = (r_state != lmn_pkg::ST_IDLE);
        unique case (r_state)
            lmn_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lmn_pkg::ST_SCAN;
                    n_idx   = lmn_pkg::CNT_W'(1);
                end
            end
            lmn_pkg::ST_SCAN: begin
                n_idx = r_idx + lmn_pkg::CNT_W'(1);
                if (int'(r_idx) == int'(eff_nodes) - 1) begin
                    n_state = lmn_pkg::ST_DRAIN;
                end
            end
            lmn_pkg::ST_DRAIN:  n_state = lmn_pkg::ST_RESULT;
            lmn_pkg::ST_RESULT: n_state = lmn_pkg::ST_IDLE;
            default:            n_state = lmn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmn_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Slot memory: written at the accepting edge, read every cycle at the scan index.
    always_ff @(posedge i_clk) begin
        if (accept && wr_en && (int'(wr_addr) < lmn_pkg::MAX_NODES)) begin
            r_slots[lmn_pkg::IDX_W'(wr_addr)] <= wr_data;
        end
        r_rd_data <= r_slots[r_idx[lmn_pkg::IDX_W-1:0]];
    end

    assign rd_value = r_rd_valid ? r_rd_data : lmn_pkg::SLOT_EMPTY;
    assign enter    = ((r_replies == peers) && (int'(r_who) == int'(r_own_id)))
                   || (r_dones == peers);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 5'd9;
            r_own_id     <= 4'd1;
            r_clock      <= 15'd0;
            r_replies    <= 5'd0;
            r_dones      <= 5'd0;
            r_slot_valid <= '0;
            r_rd_live    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    lmn_pkg::REG_NODE_COUNT: r_node_count <= pwdata[4:0];
                    lmn_pkg::REG_OWN_ID:     r_own_id     <= pwdata[3:0];
                    default:                 r_own_id     <= r_own_id;
                endcase
            end
            if (accept) begin
                r_clock   <= new_clock;
                r_replies <= new_replies;
                r_dones   <= new_dones;
                if (wr_en && (int'(wr_addr) < lmn_pkg::MAX_NODES)) begin
                    r_slot_valid[lmn_pkg::IDX_W'(wr_addr)] <= 1'b1;
                end
            end
            r_rd_live   <= (r_state == lmn_pkg::ST_SCAN);
            r_out_valid <= (r_state == lmn_pkg::ST_RESULT);
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= r_idx[lmn_pkg::IDX_W-1:0];
        r_rd_valid <= r_slot_valid[r_idx[lmn_pkg::IDX_W-1:0]];
        if (accept) begin
            r_kind  <= new_kind;
            r_dest  <= new_dest;
            r_stamp <= new_stamp;
            r_bad   <= new_bad;
            r_best  <= lmn_pkg::SLOT_EMPTY;
            r_who   <= '0;
        end else if (r_rd_live && (rd_value < r_best)) begin
            // Strict compare keeps the lowest index on a tie.
            r_best <= rd_value;
            r_who  <= r_rd_addr;
        end
        if (r_state == lmn_pkg::ST_RESULT) begin
            r_out_kind  <= r_kind;
            r_out_dest  <= r_dest;
            r_out_stamp <= r_stamp;
            r_out_clock <= r_clock;
            r_out_enter <= enter;
            r_out_bad   <= r_bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_send_kind  = r_out_kind;
    assign o_send_dest  = r_out_dest;
    assign o_send_stamp = r_out_stamp;
    assign o_clock_now  = r_out_clock;
    assign o_may_enter  = r_out_enter;
    assign o_bad_kind   = r_out_bad;

`ifndef NO_ASSERTIONS
    a_result_follows_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == lmn_pkg::ST_RESULT))
        else $error("result strobe without a publish cycle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_state == lmn_pkg::ST_SCAN))
        else $error("accepted item did not start a scan");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmn_pkg::ST_SCAN) |-> (r_idx != '0 && int'(r_idx) < int'(eff_nodes)))
        else $error("slot scan index out of range");

    a_clock_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clock_now <= lmn_pkg::CLOCK_TOP))
        else $error("clock beyond its saturation value");
`endif

endmodule
